// ----- rtl/s2cd_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// s2cd_pkg
// shared constants and stage types for the seconds to calendar date pipeline
// ----------------------------------------------------------------------------
package s2cd_pkg;

   localparam int unsigned SecsPerDay  = 86400;
   localparam int unsigned SecsPerHour = 3600;
   localparam int unsigned SecsPerMin  = 60;
   localparam int unsigned EpochYear   = 1970;

   // days since epoch fit 16 bits (max 49710)
   typedef logic [15:0] days_type;
   typedef logic [16:0] rem_type;

   // stage 1: days and the original count
   typedef struct packed {
      days_type    days;
      logic [31:0] secs;
   } st1_type;

   // stage 2: days, seconds of day, weekday
   typedef struct packed {
      days_type   days;
      rem_type    rem;
      logic [2:0] weekday;
   } st2_type;

   // stage 3: year found, day of year, hour and seconds of hour
   typedef struct packed {
      logic [11:0] year;
      logic [8:0]  yday;
      logic        leap;
      logic [4:0]  hour;
      logic [11:0] rem_hr;
      logic [2:0]  weekday;
   } st3_type;

   typedef struct packed {
      logic [11:0] year;
      logic [3:0]  month;
      logic [4:0]  day;
      logic [4:0]  hour;
      logic [5:0]  minute;
      logic [5:0]  second;
      logic [2:0]  weekday;
   } date_type;

   // days from epoch to 1 January of year 1970+i, i in 0..137
   function automatic logic [15:0] year_start(input logic [7:0] i);
      logic [15:0] acc;
      int unsigned y;
      acc = '0;
      for (int k = 0; k < 138; k++) begin
         y = EpochYear + k;
         if (k < int'(i)) begin
            acc = acc + ((((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0) ?
                         16'd366 : 16'd365);
         end
      end
      return acc;
   endfunction

   function automatic logic is_leap(input logic [11:0] y);
      return (y[1:0] == 2'b00) && (y != 12'd2100);
   endfunction

   // cumulative days before month m (0..11)
   function automatic logic [8:0] month_start(input logic [3:0] m, input logic leap);
      logic [8:0] v;
      unique case (m)
         4'd0:  v = 9'd0;
         4'd1:  v = 9'd31;
         4'd2:  v = 9'd59;
         4'd3:  v = 9'd90;
         4'd4:  v = 9'd120;
         4'd5:  v = 9'd151;
         4'd6:  v = 9'd181;
         4'd7:  v = 9'd212;
         4'd8:  v = 9'd243;
         4'd9:  v = 9'd273;
         4'd10: v = 9'd304;
         4'd11: v = 9'd334;
         default: v = 9'd365;
      endcase
      if (leap && m >= 4'd2) begin
         v = v + 9'd1;
      end
      return v;
   endfunction

endpackage
`default_nettype wire

// ----- rtl/s2cd_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// s2cd_core
// four stage conversion pipeline with a shared advance enable
// ----------------------------------------------------------------------------
module s2cd_core (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               advance,
   input  wire logic               in_valid,
   input  wire logic [31:0]        in_secs,
   output logic                    out_valid,
   output s2cd_pkg::date_type      out_date
);

   logic               v1_ff, v2_ff, v3_ff, v4_ff;
   s2cd_pkg::st1_type  s1_ff, s1_in;
   s2cd_pkg::st2_type  s2_ff, s2_in;
   s2cd_pkg::st3_type  s3_ff, s3_in;
   s2cd_pkg::date_type s4_ff, s4_in;

   // stage 1: days through reciprocal of 86400
   logic [63:0] q_prod;
   always_comb begin
      q_prod = 64'(in_secs) * 64'd3257812231;   // ceil(2^48/86400)
      s1_in.days = q_prod[63:48];
      s1_in.secs = in_secs;
   end

   // stage 2: seconds of day and weekday
   logic [31:0] r_est;
   logic [17:0] wd;
   logic [17:0] wq;
   always_comb begin
      r_est = s1_ff.secs - 32'(s1_ff.days) * 32'(s2cd_pkg::SecsPerDay);
      wd    = 18'(s1_ff.days) + 18'd4;
      wq    = 18'((40'(wd) * 40'd299594) >> 21);   // /7
      s2_in.days    = s1_ff.days;
      s2_in.rem     = r_est[16:0];
      s2_in.weekday = 3'(wd - wq * 18'd7) + 3'd1;
   end

   // stage 3: year search over constant table of year starts, hour
   logic [7:0]  yi;
   logic [15:0] ys;
   logic [4:0]  hr;
   always_comb begin
      yi = '0;
      ys = '0;
      for (int k = 1; k < 138; k++) begin
         if (s2_ff.days >= s2cd_pkg::year_start(8'(k))) begin
            yi = 8'(k);
            ys = s2cd_pkg::year_start(8'(k));
         end
      end
      hr = 5'((32'(s2_ff.rem) * 32'd37283) >> 27);   // /3600
      s3_in.year    = 12'(s2cd_pkg::EpochYear) + 12'(yi);
      s3_in.yday    = 9'(s2_ff.days - ys);
      s3_in.leap    = s2cd_pkg::is_leap(s3_in.year);
      s3_in.hour    = hr;
      s3_in.rem_hr  = 12'(s2_ff.rem - 17'(hr) * 17'(s2cd_pkg::SecsPerHour));
      s3_in.weekday = s2_ff.weekday;
   end

   // stage 4: month search, minute and second
   logic [3:0] mi;
   logic [5:0] mn;
   always_comb begin
      mi = '0;
      for (int m = 1; m < 12; m++) begin
         if (s3_ff.yday >= s2cd_pkg::month_start(4'(m), s3_ff.leap)) begin
            mi = 4'(m);
         end
      end
      mn = 6'((28'(s3_ff.rem_hr) * 28'd17477) >> 20);   // /60
      s4_in.year    = s3_ff.year;
      s4_in.month   = mi + 4'd1;
      s4_in.day     = 5'(s3_ff.yday - s2cd_pkg::month_start(mi, s3_ff.leap)) + 5'd1;
      s4_in.hour    = s3_ff.hour;
      s4_in.minute  = mn;
      s4_in.second  = 6'(s3_ff.rem_hr - 12'(mn) * 12'(s2cd_pkg::SecsPerMin));
      s4_in.weekday = s3_ff.weekday;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else if (advance) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_ff <= s1_in;
         s2_ff <= s2_in;
         s3_ff <= s3_in;
         s4_ff <= s4_in;
      end
   end

   assign out_valid = v4_ff;
   assign out_date  = s4_ff;

endmodule
`default_nettype wire

// ----- rtl/seconds_to_calendar_date.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// seconds_to_calendar_date
// converts a 32-bit seconds count since 1970 to Gregorian date and time
// ----------------------------------------------------------------------------
// usage
//   req_valid/req_stall carry a seconds count; rsp_valid/rsp_stall carry the
//   date: year, month, day, hour, minute, second, weekday (1 sunday)
//   one result per transaction, in order
//   throughput one transaction per cycle while the receiver does not stall,
//   set by the four stage pipeline: divide by a day, day remainder and
//   weekday, year lookup and hour, month lookup with minute and second
//   reset clears all valid bits; no clearing pass is needed
//   when the receiver stalls with a result waiting, the whole pipeline holds
//   and req_stall is raised until the result is taken
// ----------------------------------------------------------------------------
module seconds_to_calendar_date (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [31:0] req_seconds_count,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [11:0]      rsp_year,
   output logic [3:0]       rsp_month,
   output logic [4:0]       rsp_day,
   output logic [4:0]       rsp_hour,
   output logic [5:0]       rsp_minute,
   output logic [5:0]       rsp_second,
   output logic [2:0]       rsp_weekday
);

   logic               advance;
   s2cd_pkg::date_type date;

   assign advance   = !(rsp_valid && rsp_stall);
   assign req_stall = !advance;

   s2cd_core u_core (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (req_valid),
      .in_secs   (req_seconds_count),
      .out_valid (rsp_valid),
      .out_date  (date)
   );

   assign rsp_year    = date.year;
   assign rsp_month   = date.month;
   assign rsp_day     = date.day;
   assign rsp_hour    = date.hour;
   assign rsp_minute  = date.minute;
   assign rsp_second  = date.second;
   assign rsp_weekday = date.weekday;

endmodule
`default_nettype wire

// ----- rtl/s2cd_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// s2cd_checker
// port level checks for the seconds to calendar date block
// ----------------------------------------------------------------------------
module s2cd_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_stall,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic [3:0]  rsp_month,
   input wire logic [4:0]  rsp_day,
   input wire logic [2:0]  rsp_weekday
);

   a_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_month >= 4'd1 && rsp_month <= 4'd12 && rsp_day >= 5'd1
                     && rsp_weekday >= 3'd1))
      else $error("result field out of range");

   a_stall: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("input stalled without output back pressure");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> rsp_valid)
      else $error("stalled result lost");

   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_stall) |=> req_valid)
      else $error("stalled request withdrawn");

   a_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind seconds_to_calendar_date s2cd_checker u_s2cd_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_stall   (req_stall),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_month   (rsp_month),
   .rsp_day     (rsp_day),
   .rsp_weekday (rsp_weekday)
);
`default_nettype wire
